@@ hdl/gcc_pkg.sv @@
package gcc_pkg;

    // Field widths of the words on the ports
    localparam int IDX_W  = 5;
    localparam int MASK_W = 26;
    localparam int CH_W   = 5;
    localparam int CFG_W  = 5;

    // Default graph size
    localparam int MAX_NODES_DEF = 26;

    // Reset value of the node count register
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1);

    // Control strobes from the sequencer to the row memory
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } t_mem_ctl;

endpackage

@@ hdl/gcc_rowmem.sv @@
module gcc_rowmem #(
    parameter int DEPTH = gcc_pkg::MAX_NODES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gcc_pkg::t_mem_ctl             i_ctl,
    input  logic [$clog2(DEPTH)-1:0]      i_rd_addr,
    input  logic [$clog2(DEPTH)-1:0]      i_wr_addr,
    input  logic [DEPTH-1:0]              i_wr_data,
    output logic [DEPTH-1:0]              o_rd_data
);
    import gcc_pkg::*;

    logic [DEPTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_q;
    logic [DEPTH-1:0] r_vld;
    logic             r_q_vld;

    // Store rows and register the read word
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    // Track which rows were written since the set began
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_ctl.clr) begin
                r_vld <= '0;
            end else if (i_ctl.wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_q_vld <= r_vld[i_rd_addr];
            end
        end
    end

    // Rows not yet written read as zero
    assign o_rd_data = r_q_vld ? r_q : '0;

endmodule

@@ hdl/greedy_channel_coloring_core.sv @@
// Channel      | Direction | Handshake               | Payload
// row in       | input     | i_in_valid / o_in_stall | i_node_index, i_neighbor_mask, i_last_row
// result out   | output    | o_out_valid / i_out_stall | o_channels
// node count   | input     | i_cfg_we                | i_cfg_wdata
//
// Each row word reads, merges and writes back one row of the row memory; o_in_stall holds off the next.
// The last row then starts the greedy pass, which runs on the single row memory: each node's row
// is read, each earlier node is tested in turn, and a merge scans all n rows and then writes the
// collected column back; the pass then closes and hands off the result.
// Reset is synchronous; row valid bits clear at once, so no clearing pass runs.
// A waiting result does not block new rows; a finished pass holds until the result slot frees.
module greedy_channel_coloring_core #(
    parameter int MAX_NODES = gcc_pkg::MAX_NODES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [gcc_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [gcc_pkg::IDX_W-1:0]   i_node_index,
    input  logic [gcc_pkg::MASK_W-1:0]  i_neighbor_mask,
    input  logic                        i_last_row,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [gcc_pkg::CH_W-1:0]    o_channels
);
    import gcc_pkg::*;

    localparam int AW = $clog2(MAX_NODES);
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int MB = (MAX_NODES < MASK_W) ? MAX_NODES : MASK_W;
    localparam logic [MAX_NODES-1:0] ROW_ONE = MAX_NODES'(1);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_LD_RD   = 10'b00_0000_0010,
        S_LD_WR   = 10'b00_0000_0100,
        S_NODE_RD = 10'b00_0000_1000,
        S_NODE_WT = 10'b00_0001_0000,
        S_SEL     = 10'b00_0010_0000,
        S_SCAN    = 10'b00_0100_0000,
        S_FIN_RD  = 10'b00_1000_0000,
        S_FIN_WR  = 10'b01_0000_0000,
        S_DONE    = 10'b10_0000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_cfg;
    logic                 r_set_open, n_set_open;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [MAX_NODES-1:0] r_mask, n_mask;
    logic                 r_last, n_last;
    logic [NW-1:0]        r_i, n_i;
    logic [NW-1:0]        r_j, n_j;
    logic [NW-1:0]        r_k, n_k;
    logic [MAX_NODES-1:0] r_row, n_row;
    logic [MAX_NODES-1:0] r_acc, n_acc;
    logic                 r_merged, n_merged;
    logic [CH_W-1:0]      r_total, n_total;
    logic                 r_pend, n_pend;
    logic [NW-1:0]        r_pend_k, n_pend_k;
    logic                 r_out_vld, n_out_vld;
    logic [CH_W-1:0]      r_out_ch, n_out_ch;

    logic [NW-1:0]        w_n;
    logic [MAX_NODES-1:0] w_mask;
    logic                 w_idx_ok;
    logic                 w_in_acc;
    logic                 w_out_free;
    t_mem_ctl             w_ctl;
    logic [AW-1:0]        w_rd_addr;
    logic [AW-1:0]        w_wr_addr;
    logic [MAX_NODES-1:0] w_wr_data;
    logic [MAX_NODES-1:0] w_rd_data;

    // Saturate the node count to the store size
    always_comb begin
        if (32'(r_cfg) > 32'(MAX_NODES)) begin
            w_n = NW'(MAX_NODES);
        end else begin
            w_n = NW'(r_cfg);
        end
    end

    // Drop mask bits beyond the store
    always_comb begin
        w_mask = '0;
        w_mask[MB-1:0] = i_neighbor_mask[MB-1:0];
    end

    assign w_idx_ok   = (32'(r_idx) < 32'(MAX_NODES));
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_vld || !i_out_stall;

    gcc_rowmem #(
        .DEPTH (MAX_NODES)
    ) u_rowmem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    // Sequence row loads and the greedy pass
    always_comb begin
        n_state    = r_state;
        n_set_open = r_set_open;
        n_idx      = r_idx;
        n_mask     = r_mask;
        n_last     = r_last;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_row      = r_row;
        n_acc      = r_acc;
        n_merged   = r_merged;
        n_total    = r_total;
        n_pend     = 1'b0;
        n_pend_k   = r_pend_k;
        n_out_vld  = r_out_vld && i_out_stall;
        n_out_ch   = r_out_ch;
        w_ctl      = '0;
        w_rd_addr  = '0;
        w_wr_addr  = '0;
        w_wr_data  = '0;

        // Finish a scan read: tag the row and collect it into the column
        if (r_pend && w_rd_data[r_i[AW-1:0]]) begin
            w_ctl.wr_en = 1'b1;
            w_wr_addr   = r_pend_k[AW-1:0];
            w_wr_data   = w_rd_data | (ROW_ONE << r_j[AW-1:0]);
            n_acc       = r_acc | (ROW_ONE << r_pend_k[AW-1:0]);
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_idx  = i_node_index;
                    n_mask = w_mask;
                    n_last = i_last_row;
                    if (!r_set_open) begin
                        w_ctl.clr  = 1'b1;
                        n_set_open = 1'b1;
                    end
                    n_state = S_LD_RD;
                end
            end
            S_LD_RD: begin
                if (w_idx_ok) begin
                    w_ctl.rd_en = 1'b1;
                    w_rd_addr   = AW'(r_idx);
                end
                n_state = S_LD_WR;
            end
            S_LD_WR: begin
                if (w_idx_ok) begin
                    w_ctl.wr_en = 1'b1;
                    w_wr_addr   = AW'(r_idx);
                    w_wr_data   = w_rd_data | r_mask;
                end
                if (r_last) begin
                    n_i     = '0;
                    n_total = '0;
                    n_state = S_NODE_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_NODE_RD: begin
                if (r_i == w_n) begin
                    n_state = S_DONE;
                end else begin
                    w_ctl.rd_en = 1'b1;
                    w_rd_addr   = r_i[AW-1:0];
                    n_state     = S_NODE_WT;
                end
            end
            S_NODE_WT: begin
                n_row    = w_rd_data;
                n_j      = '0;
                n_merged = 1'b0;
                n_state  = S_SEL;
            end
            S_SEL: begin
                if (r_j == r_i) begin
                    n_total = r_total + {{(CH_W-1){1'b0}}, ~r_merged};
                    n_i     = r_i + NW'(1);
                    n_state = S_NODE_RD;
                end else if (r_row[r_j[AW-1:0]]) begin
                    n_j = r_j + NW'(1);
                end else begin
                    n_merged = 1'b1;
                    n_k      = '0;
                    n_acc    = '0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                w_ctl.rd_en = 1'b1;
                w_rd_addr   = r_k[AW-1:0];
                n_pend      = 1'b1;
                n_pend_k    = r_k;
                n_k         = r_k + NW'(1);
                if (r_k == (w_n - NW'(1))) begin
                    n_state = S_FIN_RD;
                end
            end
            S_FIN_RD: begin
                w_ctl.rd_en = 1'b1;
                w_rd_addr   = r_j[AW-1:0];
                n_state     = S_FIN_WR;
            end
            S_FIN_WR: begin
                w_ctl.wr_en = 1'b1;
                w_wr_addr   = r_j[AW-1:0];
                w_wr_data   = w_rd_data | r_acc;
                n_j         = r_j + NW'(1);
                n_state     = S_SEL;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_ch   = r_total;
                    n_set_open = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cfg      <= CFG_RESET;
            r_set_open <= 1'b0;
            r_pend     <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_set_open <= n_set_open;
            r_pend     <= n_pend;
            r_out_vld  <= n_out_vld;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_mask   <= n_mask;
        r_last   <= n_last;
        r_i      <= n_i;
        r_j      <= n_j;
        r_k      <= n_k;
        r_row    <= n_row;
        r_acc    <= n_acc;
        r_merged <= n_merged;
        r_total  <= n_total;
        r_pend_k <= n_pend_k;
        r_out_ch <= n_out_ch;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_channels  = r_out_ch;

`ifndef SYNTH
    // A scan word is only in flight during the scan or its tail
    a_pend_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SCAN || r_state == S_FIN_RD))
        else $error("scan word pending outside scan");

    // Never read and write the same row in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.rd_en && w_ctl.wr_en) |-> (w_rd_addr != w_wr_addr))
        else $error("row memory read and write collide");

    // A merge target always precedes the node being merged
    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_j < r_i))
        else $error("merge target not before current node");

    // A new result only comes out of a finished pass
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_vld && !(r_out_vld && i_out_stall)) |-> (r_state == S_DONE))
        else $error("result loaded outside done state");
`endif

endmodule
